// ===== design/average_power_estimator_top_assert.svh =====
// Assertion macros shared by the estimator RTL.
// APE_ASSERT_IMP: same-cycle implication, APE_ASSERT_NXT: next-cycle implication.
`ifndef AVERAGE_POWER_ESTIMATOR_TOP_ASSERT_SVH
`define AVERAGE_POWER_ESTIMATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define APE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define APE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define APE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define APE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/ape_pkg.sv =====
package ape_pkg;

    localparam int FIELD_W  = 32;
    localparam int COEFF_W  = 12;
    // widest weighted sum of one bit slice: 4095*(1000+1+1000+10000) < 2^26
    localparam int WEIGHT_W = 26;

    localparam int CPU_SCALE    = 1000;
    localparam int LPM_SCALE    = 1;
    localparam int TX_SCALE     = 1000;
    localparam int LISTEN_SCALE = 10000;
    localparam int TIME_SCALE   = 10000;

    localparam int CPU_COEFF_RST    = 54;
    localparam int LPM_COEFF_RST    = 1635;
    localparam int TX_COEFF_RST     = 531;
    localparam int LISTEN_COEFF_RST = 60;

    typedef enum logic [1:0] {
        CFG_CPU    = 2'd0,
        CFG_LPM    = 2'd1,
        CFG_TX     = 2'd2,
        CFG_LISTEN = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_TIME = 2'd1,
        ST_SATURATED = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_SCALE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } t_div_stat;

endpackage

// ===== design/ape_serial_div.sv =====
`include "average_power_estimator_top_assert.svh"

module ape_serial_div #(
    parameter int NUM_W = 68,
    parameter int DEN_W = 47
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NUM_W-1:0]              i_num,
    input  logic [DEN_W-1:0]              i_den,
    output ape_pkg::t_div_stat            o_stat,
    output logic [ape_pkg::FIELD_W-1:0]   o_quot
);

    localparam int Q_W   = ape_pkg::FIELD_W;
    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic             r_sat;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;

    logic [HI_W-1:0]  w_hi;
    logic             w_sat;
    logic [DEN_W:0]   w_rem2;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // quotient overflows 32 bits exactly when num >= den * 2^32
    assign w_hi   = i_num[NUM_W-1:Q_W];
    assign w_sat  = CMP_W'(w_hi) >= CMP_W'(i_den);
    assign w_rem2 = {r_rem, r_quo[Q_W-1]};
    assign w_diff = w_rem2 - {1'b0, i_den};
    assign w_ge   = w_rem2 >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_sat  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_sat <= w_sat;
                r_cnt <= '0;
                if (w_sat) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder starts as the high part (below den when not saturated);
    // low numerator bits shift out of r_quo while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DEN_W'(w_hi);
            r_quo <= i_num[Q_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem2[DEN_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.sat  = r_sat;
    assign o_quot      = r_quo;

    `APE_ASSERT_IMP(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)
    `APE_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `APE_ASSERT_IMP(a_sat_no_iter, i_clk, i_rst_n, r_busy, !r_sat)

endmodule

// ===== design/average_power_estimator_top.sv =====
// Flow: a reading accepted in idle runs through the MAC, scale and divide states
//   to done; with no cpu/low power time elapsed it goes straight to done, and
//   a saturating result leaves the divider without iterating.
// Pacing: set by the bit-serial MAC (one delta bit per cycle) and the 32-step
//   restoring divider; a reading is accepted only in idle, after the last result.
// Reset: synchronous, active low; clears previous readings, restores weights.
`include "average_power_estimator_top_assert.svh"

module average_power_estimator_top #(
    parameter int COUNTER_WIDTH   = 32,
    parameter int FRACTION_DIGITS = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [ape_pkg::COEFF_W-1:0]   i_cfg_data,
    // counter readings
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ape_pkg::FIELD_W-1:0]   i_cpu_count,
    input  logic [ape_pkg::FIELD_W-1:0]   i_low_power_count,
    input  logic [ape_pkg::FIELD_W-1:0]   i_transmit_count,
    input  logic [ape_pkg::FIELD_W-1:0]   i_listen_count,
    // results
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ape_pkg::FIELD_W-1:0]   o_cpu_ticks,
    output logic [ape_pkg::FIELD_W-1:0]   o_low_power_ticks,
    output logic [ape_pkg::FIELD_W-1:0]   o_transmit_ticks,
    output logic [ape_pkg::FIELD_W-1:0]   o_listen_ticks,
    output logic [ape_pkg::FIELD_W-1:0]   o_power_milli,
    output logic [1:0]                    o_status
);

    localparam int CW     = COUNTER_WIDTH;
    localparam int FW     = ape_pkg::FIELD_W;
    localparam int WW     = ape_pkg::WEIGHT_W;
    localparam longint unsigned P10 = 64'(10) ** FRACTION_DIGITS;
    localparam int PW     = $clog2(P10);
    // numerator: weighted sum (< 2^(CW+WW)) times 10^FRACTION_DIGITS
    localparam int NUM_W  = CW + WW + PW;
    // denominator: (cpu + lpm) * 10000
    localparam int TIME_W = $clog2(ape_pkg::TIME_SCALE);
    localparam int DEN_W  = CW + 1 + TIME_W;
    localparam int CNT_W  = $clog2(CW);

    // state and control
    ape_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_zero, n_zero;
    logic               r_o_valid, n_o_valid;

    // previous readings
    logic [CW-1:0]      r_prev_cpu, n_prev_cpu;
    logic [CW-1:0]      r_prev_lpm, n_prev_lpm;
    logic [CW-1:0]      r_prev_tx, n_prev_tx;
    logic [CW-1:0]      r_prev_lsn, n_prev_lsn;

    // scaled weights (coefficient times fixed scale)
    logic [WW-1:0]      r_w_cpu, r_w_lpm, r_w_tx, r_w_lsn;

    // deltas, rotated MSB first through the MAC, back in place after CW steps
    logic [CW-1:0]      r_dc, n_dc;
    logic [CW-1:0]      r_dl, n_dl;
    logic [CW-1:0]      r_dt, n_dt;
    logic [CW-1:0]      r_ds, n_ds;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [DEN_W-1:0]   r_den, n_den;

    // result register
    logic [FW-1:0]      r_cpu_ticks, n_cpu_ticks;
    logic [FW-1:0]      r_lpm_ticks, n_lpm_ticks;
    logic [FW-1:0]      r_tx_ticks, n_tx_ticks;
    logic [FW-1:0]      r_lsn_ticks, n_lsn_ticks;
    logic [FW-1:0]      r_power, n_power;
    ape_pkg::t_status   r_status, n_status;

    logic [CW-1:0]      w_cpu_in, w_lpm_in, w_tx_in, w_lsn_in;
    logic [CW-1:0]      w_dc, w_dl, w_dt, w_ds;
    logic [WW-1:0]      w_wsum;
    logic               w_div_start;
    ape_pkg::t_div_stat w_div_stat;
    logic [FW-1:0]      w_div_quot;

    // bits above COUNTER_WIDTH are dropped; narrower counters are zero-extended
    assign w_cpu_in = CW'(i_cpu_count);
    assign w_lpm_in = CW'(i_low_power_count);
    assign w_tx_in  = CW'(i_transmit_count);
    assign w_lsn_in = CW'(i_listen_count);

    assign w_dc = w_cpu_in - r_prev_cpu;
    assign w_dl = w_lpm_in - r_prev_lpm;
    assign w_dt = w_tx_in  - r_prev_tx;
    assign w_ds = w_lsn_in - r_prev_lsn;

    // weights selected by the current delta MSBs
    assign w_wsum = (r_dc[CW-1] ? r_w_cpu : '0) + (r_dl[CW-1] ? r_w_lpm : '0)
                  + (r_dt[CW-1] ? r_w_tx  : '0) + (r_ds[CW-1] ? r_w_lsn : '0);

    assign o_ready = (r_state == ape_pkg::S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_zero      = r_zero;
        n_o_valid   = r_o_valid;
        n_prev_cpu  = r_prev_cpu;
        n_prev_lpm  = r_prev_lpm;
        n_prev_tx   = r_prev_tx;
        n_prev_lsn  = r_prev_lsn;
        n_dc        = r_dc;
        n_dl        = r_dl;
        n_dt        = r_dt;
        n_ds        = r_ds;
        n_num       = r_num;
        n_den       = r_den;
        n_cpu_ticks = r_cpu_ticks;
        n_lpm_ticks = r_lpm_ticks;
        n_tx_ticks  = r_tx_ticks;
        n_lsn_ticks = r_lsn_ticks;
        n_power     = r_power;
        n_status    = r_status;
        w_div_start = 1'b0;

        // result taken; a new load below overrides
        if (i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ape_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_prev_cpu = w_cpu_in;
                    n_prev_lpm = w_lpm_in;
                    n_prev_tx  = w_tx_in;
                    n_prev_lsn = w_lsn_in;
                    n_dc       = w_dc;
                    n_dl       = w_dl;
                    n_dt       = w_dt;
                    n_ds       = w_ds;
                    n_num      = '0;
                    n_den      = '0;
                    n_cnt      = '0;
                    // cpu + lpm is zero only when both deltas are
                    n_zero     = (w_dc == '0) && (w_dl == '0);
                    n_state    = n_zero ? ape_pkg::S_DONE : ape_pkg::S_MAC;
                end
            end
            ape_pkg::S_MAC: begin
                // Horner over delta bits: acc = 2*acc + selected weights
                n_num = (r_num << 1) + NUM_W'(w_wsum);
                n_den = (r_den << 1)
                      + (r_dc[CW-1] ? DEN_W'(ape_pkg::TIME_SCALE) : '0)
                      + (r_dl[CW-1] ? DEN_W'(ape_pkg::TIME_SCALE) : '0);
                n_dc  = {r_dc[CW-2:0], r_dc[CW-1]};
                n_dl  = {r_dl[CW-2:0], r_dl[CW-1]};
                n_dt  = {r_dt[CW-2:0], r_dt[CW-1]};
                n_ds  = {r_ds[CW-2:0], r_ds[CW-1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CW - 1)) begin
                    n_cnt   = '0;
                    n_state = ape_pkg::S_SCALE;
                end
            end
            ape_pkg::S_SCALE: begin
                // times ten per step: 8x + 2x
                n_num = (r_num << 3) + (r_num << 1);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRACTION_DIGITS - 1)) begin
                    n_cnt   = '0;
                    n_state = ape_pkg::S_DIV_GO;
                end
            end
            ape_pkg::S_DIV_GO: begin
                w_div_start = 1'b1;
                n_state     = ape_pkg::S_DIV_WAIT;
            end
            ape_pkg::S_DIV_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = ape_pkg::S_DONE;
                end
            end
            ape_pkg::S_DONE: begin
                // wait until the result register is free or being emptied
                if (!r_o_valid || i_ready) begin
                    n_o_valid   = 1'b1;
                    n_cpu_ticks = FW'(r_dc);
                    n_lpm_ticks = FW'(r_dl);
                    n_tx_ticks  = FW'(r_dt);
                    n_lsn_ticks = FW'(r_ds);
                    if (r_zero) begin
                        n_power  = '0;
                        n_status = ape_pkg::ST_ZERO_TIME;
                    end else if (w_div_stat.sat) begin
                        n_power  = '1;
                        n_status = ape_pkg::ST_SATURATED;
                    end else begin
                        n_power  = w_div_quot;
                        n_status = ape_pkg::ST_OK;
                    end
                    n_state = ape_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ape_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ape_pkg::S_IDLE;
            r_cnt      <= '0;
            r_zero     <= 1'b0;
            r_o_valid  <= 1'b0;
            r_prev_cpu <= '0;
            r_prev_lpm <= '0;
            r_prev_tx  <= '0;
            r_prev_lsn <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_zero     <= n_zero;
            r_o_valid  <= n_o_valid;
            r_prev_cpu <= n_prev_cpu;
            r_prev_lpm <= n_prev_lpm;
            r_prev_tx  <= n_prev_tx;
            r_prev_lsn <= n_prev_lsn;
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        r_dc        <= n_dc;
        r_dl        <= n_dl;
        r_dt        <= n_dt;
        r_ds        <= n_ds;
        r_num       <= n_num;
        r_den       <= n_den;
        r_cpu_ticks <= n_cpu_ticks;
        r_lpm_ticks <= n_lpm_ticks;
        r_tx_ticks  <= n_tx_ticks;
        r_lsn_ticks <= n_lsn_ticks;
        r_power     <= n_power;
        r_status    <= n_status;
    end

    // weights are held pre-scaled; every 2-bit index selects one of the four weights
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_cpu <= WW'(ape_pkg::CPU_COEFF_RST * ape_pkg::CPU_SCALE);
            r_w_lpm <= WW'(ape_pkg::LPM_COEFF_RST * ape_pkg::LPM_SCALE);
            r_w_tx  <= WW'(ape_pkg::TX_COEFF_RST * ape_pkg::TX_SCALE);
            r_w_lsn <= WW'(ape_pkg::LISTEN_COEFF_RST * ape_pkg::LISTEN_SCALE);
        end else if (i_cfg_we) begin
            case (ape_pkg::t_cfg_idx'(i_cfg_idx))
                ape_pkg::CFG_CPU: begin
                    r_w_cpu <= WW'(i_cfg_data) * WW'(ape_pkg::CPU_SCALE);
                end
                ape_pkg::CFG_LPM: begin
                    r_w_lpm <= WW'(i_cfg_data) * WW'(ape_pkg::LPM_SCALE);
                end
                ape_pkg::CFG_TX: begin
                    r_w_tx <= WW'(i_cfg_data) * WW'(ape_pkg::TX_SCALE);
                end
                ape_pkg::CFG_LISTEN: begin
                    r_w_lsn <= WW'(i_cfg_data) * WW'(ape_pkg::LISTEN_SCALE);
                end
                default: begin
                end
            endcase
        end
    end

    // 32-step restoring divider with up-front overflow test
    ape_serial_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_div_quot)
    );

    assign o_valid           = r_o_valid;
    assign o_cpu_ticks       = r_cpu_ticks;
    assign o_low_power_ticks = r_lpm_ticks;
    assign o_transmit_ticks  = r_tx_ticks;
    assign o_listen_ticks    = r_lsn_ticks;
    assign o_power_milli     = r_power;
    assign o_status          = r_status;

    `APE_ASSERT_NXT(a_accept_next, i_clk, i_rst_n, i_valid && o_ready,
        (r_state == ape_pkg::S_MAC) || (r_state == ape_pkg::S_DONE))
    `APE_ASSERT_IMP(a_idle_div_quiet, i_clk, i_rst_n, r_state == ape_pkg::S_IDLE,
        !w_div_stat.busy)
    `APE_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, w_div_stat.done,
        r_state == ape_pkg::S_DIV_WAIT)
    `APE_ASSERT_IMP(a_zero_power, i_clk, i_rst_n,
        r_o_valid && (r_status == ape_pkg::ST_ZERO_TIME), r_power == '0)
    `APE_ASSERT_IMP(a_sat_power, i_clk, i_rst_n,
        r_o_valid && (r_status == ape_pkg::ST_SATURATED), r_power == '1)

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    // The block takes a new transaction only after the previous one is through
    localparam int LATENCY        = 70;
    localparam int CPU_MULT       = 1000;
    localparam int LPM_MULT       = 1;
    localparam int TX_MULT        = 1000;
    localparam int LISTEN_MULT    = 10000;
    localparam int TICK_MULT      = 10000;
    localparam int MILLI          = 1000;

    typedef struct packed {
        logic [ape_pkg::FIELD_W-1:0] cpu;
        logic [ape_pkg::FIELD_W-1:0] lpm;
        logic [ape_pkg::FIELD_W-1:0] tx;
        logic [ape_pkg::FIELD_W-1:0] lis;
    } t_reading;

    typedef struct packed {
        logic [ape_pkg::FIELD_W-1:0] cpu_ticks;
        logic [ape_pkg::FIELD_W-1:0] lpm_ticks;
        logic [ape_pkg::FIELD_W-1:0] tx_ticks;
        logic [ape_pkg::FIELD_W-1:0] lis_ticks;
        logic [ape_pkg::FIELD_W-1:0] power;
        ape_pkg::t_status            status;
    } t_power_result;

    // ---------------------------------------------------------------------
    // Block-facing signals; the ones the bench drives are known from time zero
    // ---------------------------------------------------------------------
    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_cfg_we   = 1'b0;
    ape_pkg::t_cfg_idx           i_cfg_idx  = ape_pkg::CFG_CPU;
    logic [ape_pkg::COEFF_W-1:0] i_cfg_data = '0;
    logic                        rd_valid   = 1'b0;
    logic                        i_ready    = 1'b0;
    t_reading                    rd_now     = '0;
    logic                        o_ready;
    logic                        o_valid;
    logic [ape_pkg::FIELD_W-1:0] o_cpu_ticks;
    logic [ape_pkg::FIELD_W-1:0] o_low_power_ticks;
    logic [ape_pkg::FIELD_W-1:0] o_transmit_ticks;
    logic [ape_pkg::FIELD_W-1:0] o_listen_ticks;
    logic [ape_pkg::FIELD_W-1:0] o_power_milli;
    logic [1:0]                  o_status;

    // ---------------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------------
    t_reading           reading_q[$];       // readings waiting to be driven
    t_power_result      pending_power_q[$]; // predicted results, oldest first
    t_reading           last_reading = '0;  // predictor copy of previous readings
    // predictor copy of the weights, indexed by register
    logic [ape_pkg::COEFF_W-1:0] weight [4] = '{12'd54, 12'd1635, 12'd531, 12'd60};
    t_reading           gen_last = '0;      // last reading queued by the generator
    int                 gap_left   = 0;
    int                 stall_left = 0;
    int                 mismatch_count = 0;
    logic               calm = 1'b0;        // no idling on either side when set

    average_power_estimator_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (rd_valid),
        .o_ready           (o_ready),
        .i_cpu_count       (rd_now.cpu),
        .i_low_power_count (rd_now.lpm),
        .i_transmit_count  (rd_now.tx),
        .i_listen_count    (rd_now.lis),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_cpu_ticks       (o_cpu_ticks),
        .o_low_power_ticks (o_low_power_ticks),
        .o_transmit_ticks  (o_transmit_ticks),
        .o_listen_ticks    (o_listen_ticks),
        .o_power_milli     (o_power_milli),
        .o_status          (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Power predictor: deltas modulo 2^32, exact weighted sum, floored
    // quotient in thousandths, with the zero-time and saturation cases.
    // Updates the stored readings on every transaction.
    // ---------------------------------------------------------------------
    function automatic t_power_result predict_power(t_reading r);
        t_power_result res;
        logic [127:0]  weighted;
        logic [127:0]  time_base;
        logic [127:0]  quotient;
        res.cpu_ticks = r.cpu - last_reading.cpu;
        res.lpm_ticks = r.lpm - last_reading.lpm;
        res.tx_ticks  = r.tx  - last_reading.tx;
        res.lis_ticks = r.lis - last_reading.lis;
        last_reading  = r;
        if (res.cpu_ticks == '0 && res.lpm_ticks == '0) begin
            res.power  = '0;
            res.status = ape_pkg::ST_ZERO_TIME;
        end else begin
            weighted = 128'(res.cpu_ticks) * weight[ape_pkg::CFG_CPU]    * CPU_MULT
                     + 128'(res.lpm_ticks) * weight[ape_pkg::CFG_LPM]    * LPM_MULT
                     + 128'(res.tx_ticks)  * weight[ape_pkg::CFG_TX]     * TX_MULT
                     + 128'(res.lis_ticks) * weight[ape_pkg::CFG_LISTEN] * LISTEN_MULT;
            time_base = (128'(res.cpu_ticks) + 128'(res.lpm_ticks)) * TICK_MULT;
            quotient  = (weighted * MILLI) / time_base;
            if (quotient > 128'hFFFF_FFFF) begin
                res.power  = '1;
                res.status = ape_pkg::ST_SATURATED;
            end else begin
                res.power  = quotient[ape_pkg::FIELD_W-1:0];
                res.status = ape_pkg::ST_OK;
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Mismatch reporting: one line per mismatch, each one counted
    // ---------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [ape_pkg::FIELD_W-1:0] got,
                               logic [ape_pkg::FIELD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_result();
        t_power_result want;
        if (pending_power_q.size() == 0) begin
            report_mismatch("result transaction with nothing pending");
        end else begin
            want = pending_power_q.pop_front();
            check_field("cpu_ticks",       o_cpu_ticks,       want.cpu_ticks);
            check_field("low_power_ticks", o_low_power_ticks, want.lpm_ticks);
            check_field("transmit_ticks",  o_transmit_ticks,  want.tx_ticks);
            check_field("listen_ticks",    o_listen_ticks,    want.lis_ticks);
            check_field("power_milli",     o_power_milli,     want.power);
            check_field("status",          32'(o_status),     32'(want.status));
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: pops the next reading once the previous one is accepted,
    // with occasional idle gaps after a transaction.
    // The prediction is made at the edge the reading is accepted.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (rd_valid && o_ready)
                pending_power_q.push_back(predict_power(rd_now));
            if (!rd_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    rd_valid <= 1'b0;
                end else if (reading_q.size() != 0) begin
                    rd_now   <= reading_q.pop_front();
                    rd_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0)
                        gap_left <= $urandom_range(1, 13);
                end else begin
                    rd_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: checks every accepted result transaction and back-pressures
    // the block in occasional bursts.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready)
                check_result();
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 12);
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic push_reading(logic [ape_pkg::FIELD_W-1:0] c,
                                logic [ape_pkg::FIELD_W-1:0] l,
                                logic [ape_pkg::FIELD_W-1:0] t,
                                logic [ape_pkg::FIELD_W-1:0] s);
        gen_last = '{cpu: c, lpm: l, tx: t, lis: s};
        reading_q.push_back(gen_last);
    endtask

    // Tick advance between readings: mostly realistic, sometimes a full wrap
    function automatic logic [ape_pkg::FIELD_W-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return $urandom_range(1, 1000);
            4, 5:    return $urandom_range(0, 32'h000F_FFFF);
            6:       return $urandom();
            7:       return 32'hFFFF_FFFF - $urandom_range(0, 1000); // stepped backwards
            default: return $urandom_range(1, 3);
        endcase
    endfunction

    // Random weight over the full register range
    function automatic logic [ape_pkg::COEFF_W-1:0] rand_coeff();
        logic [31:0] r;
        r = $urandom_range(0, 4095);
        return r[ape_pkg::COEFF_W-1:0];
    endfunction

    task automatic make_random_items(int count);
        int unsigned                 kind;
        logic [ape_pkg::FIELD_W-1:0] dc, dl, dt, ds;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            dt   = pick_delta();
            ds   = pick_delta();
            if (kind < 5) begin
                // no cpu or low power time elapsed
                dc = '0;
                dl = '0;
            end else if (kind < 12) begin
                // tiny time base against heavy radio use: drives saturation
                dc = $urandom_range(1, 3);
                dl = '0;
                dt = $urandom();
                ds = $urandom();
            end else begin
                dc = pick_delta();
                dl = pick_delta();
            end
            if (kind >= 92)
                push_reading($urandom(), $urandom(), $urandom(), $urandom());
            else
                push_reading(gen_last.cpu + dc, gen_last.lpm + dl,
                             gen_last.tx + dt, gen_last.lis + ds);
        end
    endtask

    // Sample at the falling edge so the clocked blocks have settled
    task automatic wait_drained();
        do @(negedge i_clk);
        while (reading_q.size() != 0 || rd_valid || pending_power_q.size() != 0);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // One register write per edge; the enable is dropped by program_all
    task automatic program_weight(ape_pkg::t_cfg_idx idx,
                                  logic [ape_pkg::COEFF_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        weight[idx] = val;
    endtask

    task automatic program_all(logic [ape_pkg::COEFF_W-1:0] c,
                               logic [ape_pkg::COEFF_W-1:0] l,
                               logic [ape_pkg::COEFF_W-1:0] t,
                               logic [ape_pkg::COEFF_W-1:0] s);
        program_weight(ape_pkg::CFG_CPU, c);
        program_weight(ape_pkg::CFG_LPM, l);
        program_weight(ape_pkg::CFG_TX, t);
        program_weight(ape_pkg::CFG_LISTEN, s);
        i_cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Sequence of phases; each weight setting is applied only once the
    // block has returned every pending result.
    // ---------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset weights, directed readings first
        push_reading(32'h0, 32'h0, 32'h0, 32'h0);           // nothing elapsed since reset
        push_reading(32'd100, 32'd900, 32'd50, 32'd200);
        push_reading(32'd100, 32'd900, 32'd50, 32'd200);     // identical reading
        push_reading(32'd100, 32'd900, 32'd1000, 32'd5000);  // radio only, no cpu/lpm time
        push_reading(32'd10, 32'd5, 32'd3, 32'd2);           // every counter wraps
        push_reading('1, '1, '1, '1);
        push_reading(32'h0, 32'h0, 32'h0, 32'h0);           // one tick each
        push_reading(32'd5, 32'h0, 32'h0, 32'h0);           // low power delta zero
        push_reading(32'd5, 32'd7, 32'h0, 32'h0);           // cpu delta zero
        push_reading(32'd6, 32'd7, 32'hFFFF_FFFE, 32'hFFFF_FFFE); // saturates
        push_reading(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        push_reading(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        push_reading(32'hD555_5555, 32'h2AAA_AAAA, 32'hD555_5555, 32'h2AAA_AAAA);
        wait_drained();     // sender holds off until every result is back
        make_random_items(300);
        wait_drained();

        // Heaviest weights
        program_all('1, '1, '1, '1);
        make_random_items(280);
        wait_drained();

        // All weights zero: power always 0, with zero-time status when no time elapsed
        program_all('0, '0, '0, '0);
        make_random_items(250);
        wait_drained();

        // Quotient = 100 + transmit delta when cpu delta is 100:
        // one reading lands exactly on the 32-bit limit, the next just past it
        program_all(12'd1, 12'd0, 12'd1, 12'd0);
        push_reading(gen_last.cpu + 32'd100, gen_last.lpm,
                     gen_last.tx + 32'hFFFF_FF9B, gen_last.lis);
        push_reading(gen_last.cpu + 32'd100, gen_last.lpm,
                     gen_last.tx + 32'hFFFF_FF9C, gen_last.lis);
        make_random_items(250);
        wait_drained();

        program_all(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
        make_random_items(300);
        wait_drained();

        // Final stretch at full rate with no idling on either side
        program_all(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
        calm = 1'b1;
        make_random_items(270);
        wait_drained();

        if (pending_power_q.size() != 0)
            report_mismatch("results still pending at the end");
        if (mismatch_count == 0)
            $display("average_power_estimator_top regression: pass");
        else
            $display("average_power_estimator_top regression: fail");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("average_power_estimator_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ape_pkg.sv
design/ape_serial_div.sv
design/average_power_estimator_top.sv
tb/tb_top.sv
